>>> hdl/pec_pkg.sv
// shared types and constants for the permutation enumerator
// used by pec_seq and permutation_enumerator_unit; no dependencies

package pec_pkg;

    localparam int NIB_W    = 4;
    localparam int PERM_W   = 32;
    localparam int PACK_POS = PERM_W / NIB_W;
    localparam int IN_TDATA_W  = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    // register index carried in paddr[2]
    localparam logic REG_N_USED = 1'b0;

    localparam logic [NIB_W-1:0] N_USED_RESET = 4'd3;

    typedef struct packed {
        logic [PERM_W-1:0] perm_packed;
        logic              is_final;
        logic              exhausted;
    } t_result;

endpackage

>>> hdl/pec_mem.sv
// ordering store: one write port, two registered read ports
// depends on nothing but its parameters

module pec_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_ra,
    input  logic [AW-1:0] i_rb,
    output logic [DW-1:0] o_qa,
    output logic [DW-1:0] o_qb
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_qa;
    logic [DW-1:0] r_qb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qa <= r_mem[i_ra];
        r_qb <= r_mem[i_rb];
    end

    assign o_qa = r_qa;
    assign o_qb = r_qb;

endmodule

>>> hdl/pec_seq.sv
// sequencer for the next-ordering steps: pivot scan, successor scan, swap, reversal
// drives pec_mem through one compare unit; uses pec_pkg

module pec_seq #(
    parameter int MAX_N = 8,
    parameter int AW    = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_restart,
    input  logic [pec_pkg::NIB_W-1:0] i_n,
    input  logic                      i_out_free,
    output logic                      o_ready,
    output logic                      o_res_valid,
    output pec_pkg::t_result          o_res,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic [pec_pkg::NIB_W-1:0] o_wdata,
    output logic [AW-1:0]             o_ra,
    output logic [AW-1:0]             o_rb,
    input  logic [pec_pkg::NIB_W-1:0] i_qa,
    input  logic [pec_pkg::NIB_W-1:0] i_qb
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_INIT   = 10'b00_0000_0010,
        ST_PSET   = 10'b00_0000_0100,
        ST_PSCAN  = 10'b00_0000_1000,
        ST_SUCC   = 10'b00_0001_0000,
        ST_SWAP   = 10'b00_0010_0000,
        ST_RSET   = 10'b00_0100_0000,
        ST_REV_A  = 10'b00_1000_0000,
        ST_REV_B  = 10'b01_0000_0000,
        ST_RESULT = 10'b10_0000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_pa, n_pa;
    logic [AW-1:0]               r_pb, n_pb;
    logic [AW-1:0]               r_piv, n_piv;
    logic [AW-1:0]               r_j, n_j;
    logic [AW-1:0]               r_k, n_k;
    logic [pec_pkg::NIB_W-1:0]   r_pv, n_pv;
    logic [pec_pkg::NIB_W-1:0]   r_t, n_t;
    logic                        r_chk, n_chk;
    logic                        r_started, n_started;
    logic                        r_done, n_done;
    logic                        r_fin, n_fin;
    logic                        r_exh, n_exh;
    logic [pec_pkg::PERM_W-1:0]  r_shadow, n_shadow;

    logic [AW-1:0]               w_top;
    logic [AW-1:0]               w_top_m1;
    logic [pec_pkg::NIB_W-1:0]   w_k4;
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [pec_pkg::NIB_W-1:0]   w_wdata;
    logic [pec_pkg::PERM_W-1:0]  w_mask;

    assign w_top    = AW'(i_n - 4'd1);
    assign w_top_m1 = AW'(i_n - 4'd2);
    assign w_k4     = pec_pkg::NIB_W'(r_k);

    always_comb begin
        n_state   = r_state;
        n_pa      = r_pa;
        n_pb      = r_pb;
        n_piv     = r_piv;
        n_j       = r_j;
        n_k       = r_k;
        n_pv      = r_pv;
        n_t       = r_t;
        n_chk     = r_chk;
        n_started = r_started;
        n_done    = r_done;
        n_fin     = r_fin;
        n_exh     = r_exh;
        w_we      = 1'b0;
        w_waddr   = r_pa;
        w_wdata   = i_qb;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_restart || !r_started) begin
                        n_k       = '0;
                        n_started = 1'b1;
                        n_done    = 1'b0;
                        n_state   = ST_INIT;
                    end else if (r_done || (i_n < 4'd2)) begin
                        n_done  = 1'b1;
                        n_exh   = 1'b1;
                        n_fin   = 1'b0;
                        n_state = ST_RESULT;
                    end else begin
                        n_pa    = w_top_m1;
                        n_pb    = w_top;
                        n_chk   = 1'b0;
                        n_state = ST_PSCAN;
                    end
                end
            end
            ST_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_k;
                w_wdata = (w_k4 < i_n) ? (w_k4 + 4'd1) : '0;
                if (r_k == AW'(MAX_N - 1)) begin
                    // identity only lacks a successor when one value is used
                    n_fin   = (i_n == 4'd1);
                    n_done  = (i_n == 4'd1);
                    n_exh   = 1'b0;
                    n_state = ST_RESULT;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            ST_PSET: begin
                n_pa    = w_top_m1;
                n_pb    = w_top;
                n_state = ST_PSCAN;
            end
            ST_PSCAN: begin
                if (i_qa < i_qb) begin
                    if (!r_chk) begin
                        n_piv   = r_pa;
                        n_pv    = i_qa;
                        n_pb    = w_top;
                        n_state = ST_SUCC;
                    end else begin
                        n_fin   = 1'b0;
                        n_exh   = 1'b0;
                        n_state = ST_RESULT;
                    end
                end else if (r_pa == '0) begin
                    n_done  = 1'b1;
                    n_fin   = r_chk;
                    n_exh   = !r_chk;
                    n_state = ST_RESULT;
                end else begin
                    n_pa = r_pa - AW'(1);
                    n_pb = r_pa;
                end
            end
            ST_SUCC: begin
                if ((r_pb > r_piv) && (i_qb <= r_pv)) begin
                    n_pb = r_pb - AW'(1);
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_piv;
                    w_wdata = i_qb;
                    n_j     = r_pb;
                    n_chk   = 1'b1;
                    n_state = ST_SWAP;
                end
            end
            ST_SWAP: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_pv;
                n_state = ST_RSET;
            end
            ST_RSET: begin
                n_pa = r_piv + AW'(1);
                n_pb = w_top;
                if (({1'b0, r_piv} + (AW+1)'(1)) < {1'b0, w_top}) begin
                    n_state = ST_REV_A;
                end else begin
                    n_state = ST_PSET;
                end
            end
            ST_REV_A: begin
                w_we    = 1'b1;
                w_waddr = r_pa;
                w_wdata = i_qb;
                n_t     = i_qa;
                n_state = ST_REV_B;
            end
            ST_REV_B: begin
                w_we    = 1'b1;
                w_waddr = r_pb;
                w_wdata = r_t;
                n_pa    = r_pa + AW'(1);
                n_pb    = r_pb - AW'(1);
                if (({1'b0, r_pa} + (AW+1)'(2)) < {1'b0, r_pb}) begin
                    n_state = ST_REV_A;
                end else begin
                    n_state = ST_PSET;
                end
            end
            ST_RESULT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // copy of the low positions, kept for the packed result
    always_comb begin
        n_shadow = r_shadow;
        for (int p = 0; p < pec_pkg::PACK_POS; p++) begin
            if (w_we && (int'(w_waddr) == p)) begin
                n_shadow[p*pec_pkg::NIB_W +: pec_pkg::NIB_W] = w_wdata;
            end
        end
    end

    always_comb begin
        for (int p = 0; p < pec_pkg::PACK_POS; p++) begin
            w_mask[p*pec_pkg::NIB_W +: pec_pkg::NIB_W] =
                (p < int'(i_n)) ? {pec_pkg::NIB_W{1'b1}} : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_piv    <= n_piv;
        r_j      <= n_j;
        r_k      <= n_k;
        r_pv     <= n_pv;
        r_t      <= n_t;
        r_chk    <= n_chk;
        r_fin    <= n_fin;
        r_exh    <= n_exh;
        r_shadow <= n_shadow;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_RESULT);

    assign o_res.perm_packed = r_exh ? '0 : (r_shadow & w_mask);
    assign o_res.is_final    = r_exh ? 1'b0 : r_fin;
    assign o_res.exhausted   = r_exh;

    assign o_we    = w_we;
    assign o_waddr = w_waddr;
    assign o_wdata = w_wdata;
    assign o_ra    = n_pa;
    assign o_rb    = n_pb;

endmodule

>>> hdl/permutation_enumerator_unit.sv
// a restart or first request writes every position of the identity ordering; a next request
// is worked by the single compare unit and one write port stepping the pivot scan, successor
// scan, swap, reversal and final-ordering scan
// throughput: one request at a time; the next is taken once the result moves to the output
// register; reset is synchronous active low: n_used returns to 3, the run restarts
// top level: apb register, stream channels, output register; uses pec_pkg, pec_seq, pec_mem

module permutation_enumerator_unit #(
    parameter int MAX_N = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pec_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] restart
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pec_pkg::PERM_W-1:0]         m_axis_tdata,  // [31:0] perm_packed
    output logic                               m_axis_tlast,  // is_final
    output logic                               m_axis_tuser,  // [0] exhausted
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pec_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pec_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pec_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    logic [pec_pkg::NIB_W-1:0] r_n_used;
    logic [pec_pkg::NIB_W-1:0] w_n;
    logic                      w_cfg_wr;
    logic                      w_reg_sel;

    logic                      w_ready;
    logic                      w_start;
    logic                      w_out_free;
    logic                      w_res_valid;
    pec_pkg::t_result          w_res;

    logic                      r_ovalid;
    pec_pkg::t_result          r_ores;

    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [pec_pkg::NIB_W-1:0] w_wdata;
    logic [AW-1:0]             w_ra;
    logic [AW-1:0]             w_rb;
    logic [pec_pkg::NIB_W-1:0] w_qa;
    logic [pec_pkg::NIB_W-1:0] w_qb;

    // configuration
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[2] == pec_pkg::REG_N_USED);
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_reg_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_used <= pec_pkg::N_USED_RESET;
        end else if (w_cfg_wr) begin
            r_n_used <= pwdata[pec_pkg::NIB_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? pec_pkg::CFG_DATA_W'(r_n_used) : '0;

    // zero counts as one, large values saturate
    always_comb begin
        if (r_n_used == '0) begin
            w_n = 4'd1;
        end else if (r_n_used > pec_pkg::NIB_W'(MAX_N)) begin
            w_n = pec_pkg::NIB_W'(MAX_N);
        end else begin
            w_n = r_n_used;
        end
    end

    // handshake
    assign s_axis_tready = w_ready;
    assign w_start       = s_axis_tvalid && w_ready;
    assign w_out_free    = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_valid && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_out_free) begin
            r_ores <= w_res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_ores.perm_packed;
    assign m_axis_tlast  = r_ores.is_final;
    assign m_axis_tuser  = r_ores.exhausted;

    pec_seq #(
        .MAX_N (MAX_N),
        .AW    (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_restart   (s_axis_tdata[0]),
        .i_n         (w_n),
        .i_out_free  (w_out_free),
        .o_ready     (w_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_ra        (w_ra),
        .o_rb        (w_rb),
        .i_qa        (w_qa),
        .i_qb        (w_qb)
    );

    pec_mem #(
        .DEPTH (MAX_N),
        .AW    (AW),
        .DW    (pec_pkg::NIB_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_ra    (w_ra),
        .i_rb    (w_rb),
        .o_qa    (w_qa),
        .o_qb    (w_qb)
    );

endmodule
